>>> hw/rtl/ptw_pkg.sv
// Shared types, codes and constants of the four-level page-table walker.
`default_nettype none

package ptw_pkg;

  localparam int TABLE_FRAMES_DEFAULT = 16;
  localparam int IDX_W = 9;
  localparam int ENTRIES_PER_FRAME = 512;
  localparam int ENTRY_W = 52;
  localparam int PAGE_W = 40;
  localparam int FLAG_W = 12;
  localparam int VA_W = 48;
  localparam int ROOT_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [FLAG_W-1:0] FLAG_PRESENT = 12'h001;
  localparam logic [FLAG_W-1:0] FLAG_WRITE = 12'h002;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd1;

  typedef enum logic [1:0] {
    FUNC_MAP       = 2'd0,
    FUNC_UNMAP     = 2'd1,
    FUNC_TRANSLATE = 2'd2,
    FUNC_READ_RAW  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_NO_FRAMES  = 2'd1,
    ST_NOT_MAPPED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RES_DONE,
    RES_NO_FRAMES,
    RES_NOT_MAPPED,
    RES_LOOKUP
  } res_sel_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_RD,
    S_EVAL,
    S_ZERO,
    S_LINK,
    S_DONE
  } ptw_state_t;

  typedef struct packed {
    func_t               func;
    logic [VA_W-1:0]     vaddr;
    logic [ENTRY_W-1:0]  phys_addr;
    logic [FLAG_W-1:0]   attr_flags;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [ENTRY_W-1:0]  value;
  } out_item_t;

  typedef struct packed {
    logic     accept;
    logic     rd;
    logic     follow;
    logic     alloc;
    logic     zero_wr;
    logic     clr_wr;
    logic     link_wr;
    logic     leaf_wr;
    logic     set_res;
    res_sel_t res_sel;
    logic     load_out;
  } ptw_cmd_t;

  typedef struct packed {
    logic  root_ok;
    logic  present;
    logic  child_ok;
    logic  pool_full;
    logic  level_last;
    logic  clr_last;
    logic  zero_last;
    func_t func;
    logic  out_busy;
  } ptw_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ptw_ctrl.sv
// Sequencer that steps the walker datapath through clearing, walking and allocation.
`default_nettype none

module ptw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ptw_pkg::ptw_stat_t stat,
  output ptw_pkg::ptw_cmd_t       cmd
);
  import ptw_pkg::*;

  ptw_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.root_ok) begin
          cmd.rd = 1'b1;
          state_next = S_EVAL;
        end else begin
          cmd.set_res = 1'b1;
          cmd.res_sel = (stat.func == FUNC_MAP) ? RES_NO_FRAMES : RES_NOT_MAPPED;
          state_next = S_DONE;
        end
      end
      S_RD: begin
        // A map writes its leaf without looking at the old one.
        if (stat.level_last && stat.func == FUNC_MAP) begin
          cmd.leaf_wr = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_DONE;
          state_next = S_DONE;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.level_last) begin
          cmd.set_res = 1'b1;
          if (stat.func == FUNC_UNMAP) begin
            cmd.leaf_wr = 1'b1;
            cmd.res_sel = stat.present ? RES_DONE : RES_NOT_MAPPED;
          end else begin
            cmd.res_sel = stat.present ? RES_LOOKUP : RES_NOT_MAPPED;
          end
          state_next = S_DONE;
        end else if (stat.present) begin
          if (stat.child_ok) begin
            cmd.follow = 1'b1;
            state_next = S_RD;
          end else begin
            cmd.set_res = 1'b1;
            cmd.res_sel = (stat.func == FUNC_MAP) ? RES_NO_FRAMES : RES_NOT_MAPPED;
            state_next = S_DONE;
          end
        end else if (stat.func == FUNC_MAP) begin
          if (stat.pool_full) begin
            cmd.set_res = 1'b1;
            cmd.res_sel = RES_NO_FRAMES;
            state_next = S_DONE;
          end else begin
            cmd.alloc = 1'b1;
            state_next = S_ZERO;
          end
        end else begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_NOT_MAPPED;
          state_next = S_DONE;
        end
      end
      S_ZERO: begin
        cmd.zero_wr = 1'b1;
        if (stat.zero_last) begin
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link_wr = 1'b1;
        state_next = S_RD;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/ptw_datapath.sv
// Table memory, walk registers, frame allocator, configuration and result registers.
`default_nettype none

module ptw_datapath #(
  parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ptw_pkg::ptw_cmd_t               cmd,
  output ptw_pkg::ptw_stat_t                   stat,
  input  wire ptw_pkg::in_item_t               in_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ptw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ptw_pkg::PAGE_W-1:0]      cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output ptw_pkg::out_item_t                   out_data
);
  import ptw_pkg::*;

  localparam int FW = $clog2(TABLE_FRAMES);
  localparam int AW = FW + IDX_W;
  localparam int DEPTH = TABLE_FRAMES * ENTRIES_PER_FRAME;

  logic [ENTRY_W-1:0] mem [DEPTH];

  logic [ROOT_W-1:0]  root_frame;
  logic [PAGE_W-1:0]  pool_base_page;
  in_item_t           req;
  logic [FW-1:0]      frame;
  logic [FW-1:0]      alloc_frame;
  logic [1:0]         level;
  logic [FW:0]        frames_used;
  logic [AW-1:0]      sweep;
  logic [ENTRY_W-1:0] rd_data;
  out_item_t          res;

  logic [31:0]        root_wide;
  logic [IDX_W-1:0]   idx;
  logic [AW-1:0]      walk_addr;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               wr_en;
  logic [PAGE_W-1:0]  child_rel;
  logic [PAGE_W-1:0]  alloc_page;

  assign cfg_ready = 1'b1;
  assign root_wide = 32'(root_frame);
  assign child_rel = rd_data[ENTRY_W-1:FLAG_W] - pool_base_page;
  assign alloc_page = pool_base_page + PAGE_W'(alloc_frame);

  always_comb begin
    case (level)
      2'd0:    idx = req.vaddr[47:39];
      2'd1:    idx = req.vaddr[38:30];
      2'd2:    idx = req.vaddr[29:21];
      default: idx = req.vaddr[20:12];
    endcase
  end

  assign walk_addr = {frame, idx};

  always_comb begin
    wr_en = cmd.clr_wr | cmd.zero_wr | cmd.link_wr | cmd.leaf_wr;
    wr_addr = walk_addr;
    wr_data = '0;
    if (cmd.clr_wr) begin
      wr_addr = sweep;
    end else if (cmd.zero_wr) begin
      wr_addr = {alloc_frame, sweep[IDX_W-1:0]};
    end else if (cmd.link_wr) begin
      wr_data = {alloc_page, req.attr_flags | FLAG_PRESENT | FLAG_WRITE};
    end else if (cmd.leaf_wr && req.func == FUNC_MAP) begin
      wr_data = {req.phys_addr[ENTRY_W-1:FLAG_W], req.attr_flags | FLAG_PRESENT};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[walk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_frame <= '0;
      pool_base_page <= PAGE_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROOT_FRAME: root_frame <= cfg_data[ROOT_W-1:0];
        CFG_POOL_BASE:  pool_base_page <= cfg_data;
        default: ;
      endcase
    end
  end

  // Walk registers: the request, the current table frame and the level.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
      level <= '0;
    end else if (cmd.accept) begin
      frame <= root_wide[FW-1:0];
      level <= '0;
    end else if (cmd.follow) begin
      frame <= child_rel[FW-1:0];
      level <= level + 2'd1;
    end else if (cmd.link_wr) begin
      frame <= alloc_frame;
      level <= level + 2'd1;
    end
  end

  // Frames are handed out from a bump counter; frame zero is reserved.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_used <= (FW + 1)'(1);
      alloc_frame <= '0;
    end else if (cmd.alloc) begin
      frames_used <= frames_used + (FW + 1)'(1);
      alloc_frame <= frames_used[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.alloc) begin
      sweep <= '0;
    end else if (cmd.clr_wr || cmd.zero_wr) begin
      sweep <= sweep + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      case (cmd.res_sel)
        RES_DONE: begin
          res.status <= ST_DONE;
          res.value <= '0;
        end
        RES_NO_FRAMES: begin
          res.status <= ST_NO_FRAMES;
          res.value <= '0;
        end
        RES_LOOKUP: begin
          res.status <= ST_DONE;
          res.value <= (req.func == FUNC_TRANSLATE) ?
                       {rd_data[ENTRY_W-1:FLAG_W], {FLAG_W{1'b0}}} : rd_data;
        end
        default: begin
          res.status <= ST_NOT_MAPPED;
          res.value <= '0;
        end
      endcase
    end
  end

  // The output register lets a finished result wait while the next request walks.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= res;
    end
  end

  always_comb begin
    stat.root_ok = root_wide < 32'(TABLE_FRAMES);
    stat.present = rd_data[0];
    stat.child_ok = child_rel < PAGE_W'(TABLE_FRAMES);
    stat.pool_full = frames_used == (FW + 1)'(TABLE_FRAMES);
    stat.level_last = level == 2'd3;
    stat.clr_last = sweep == AW'(DEPTH - 1);
    stat.zero_last = sweep[IDX_W-1:0] == {IDX_W{1'b1}};
    stat.func = req.func;
    stat.out_busy = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

>>> hw/rtl/four_level_page_table_walker_core.sv
// Top level of the four-level page-table walker: sequencer plus table datapath.
`default_nettype none

// Walks a four-level page table kept in a private single-port table memory of
// TABLE_FRAMES frames of 512 entries. After reset the block zeroes the whole
// memory, one entry a cycle, and takes no request until that is done;
// configuration writes are taken at any time. Every table level costs one
// memory read and an evaluation step, except that a map writes its leaf entry
// without reading it. Each new table that a map has to create is zeroed,
// one entry a cycle, before the link to it is written. A finished result sits in
// an output register, so the next request can be taken while it waits.
module four_level_page_table_walker_core #(
  parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire ptw_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output ptw_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ptw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ptw_pkg::PAGE_W-1:0]    cfg_data
);
  import ptw_pkg::*;

  ptw_cmd_t  cmd;
  ptw_stat_t stat;

  ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptw_datapath #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
